// ===== sv/fixed_point_alu_with_activations_assert.svh =====
// Assertion macros used by the checker file of the fixed-point ALU
`ifndef FIXED_POINT_ALU_WITH_ACTIVATIONS_ASSERT_SVH
`define FIXED_POINT_ALU_WITH_ACTIVATIONS_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpa assertion failed");

// Next-cycle implication, ignored while reset is high
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpa assertion failed");

// Next-cycle implication that also holds across reset
`define FPA_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpa assertion failed");

`endif

// ===== sv/fpa_pkg.sv =====
// Package: operation codes, format constants and the piecewise-linear tanh
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int DW = 16;
  localparam int FB_MIN = 6;
  localparam int FB_MAX = 13;
  localparam logic [3:0] FB_RESET = 4'd10;

  // Divider is radix-2 restoring over a 32-bit padded dividend
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = 8;
  localparam int NUM_STAGES = DIV_STAGES + 2;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_NEG     = 4'd4,
    OP_ABS     = 4'd5,
    OP_CONVERT = 4'd6,
    OP_BLEND   = 4'd7,
    OP_TANH    = 4'd8,
    OP_SIGMOID = 4'd9,
    OP_INT2FIX = 4'd10
  } op_t;

  // Odd-symmetric piecewise-linear tanh with a clamp at one
  function automatic word_t tanh_pwl(input word_t x, input logic [3:0] p);
    logic inv;
    word_t xm;
    logic signed [17:0] xe, fourth, half, one, two, r, q;
    inv = x[DW-1];
    xm = inv ? -x : x;
    xe = 18'(xm);
    one = 18'sd1 <<< p;
    two = one <<< 1;
    half = one >>> 1;
    fourth = one >>> 2;
    q = xe >>> 2;
    r = one;
    if (xe <= fourth) begin
      r = xe;
    end else if (xe <= fourth + half) begin
      r = (q <<< 1) + q + ((one >>> 6) <<< 2) + (one >>> 6);
    end else if (xe <= one + fourth) begin
      r = (xe >>> 1) + fourth;
    end else if (xe <= two + fourth) begin
      r = (xe >>> 3) + half + fourth - (one >>> 5);
      if (r > one) r = one;
    end
    return inv ? -(r[DW-1:0]) : r[DW-1:0];
  endfunction

endpackage

// ===== sv/fpa_req_if.sv =====
// Interface: request channel carrying one operation item
`timescale 1ns / 1ps

interface fpa_req_if;
  import fpa_pkg::*;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  word_t       operand_a;
  word_t       operand_b;
  word_t       gate_value;
  logic [3:0]  old_frac_bits;
  logic [3:0]  new_frac_bits;
  logic [4:0]  new_width;

  modport source (output valid, op, operand_a, operand_b, gate_value,
                  old_frac_bits, new_frac_bits, new_width, input ready);
  modport sink   (input valid, op, operand_a, operand_b, gate_value,
                  old_frac_bits, new_frac_bits, new_width, output ready);
endinterface

// ===== sv/fpa_rsp_if.sv =====
// Interface: response channel carrying one result item
`timescale 1ns / 1ps

interface fpa_rsp_if;
  import fpa_pkg::*;
  logic  valid;
  logic  ready;
  word_t result;
  logic  divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

// ===== sv/fpa_cfg_if.sv =====
// Interface: configuration write channel for the fraction-bit register
`timescale 1ns / 1ps

interface fpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/fixed_point_alu_with_activations.sv =====
// Every stage has a valid bit and stalls only when it is full and the next stage stalls.
// Throughput: one item per cycle while the output is not stalled.
// Depth is set by the divider: 32 restoring steps, 4 quotient bits per stage over 8 stages.
// Reset clears all valid bits and loads frac_bits with 10; the payload is not reset.
// Configuration writes are always taken; frac_bits is clamped to 6..13 where it is used.
`timescale 1ns / 1ps

module fixed_point_alu_with_activations (
  input logic clk,
  input logic rst,
  fpa_cfg_if.sink   cfg,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         p;
    word_t              a;
    word_t              b;
    word_t              g;
    word_t              omg;
    word_t              res;
    logic               dz;
    word_t              targ;
    word_t              t;
    logic               neg_in;
    logic signed [31:0] prod_ab;
    logic signed [31:0] prod_ag;
    logic signed [31:0] prod_bo;
    logic [16:0]        rem;
    logic [31:0]        dvd;
    logic [15:0]        dvs;
    logic [15:0]        quo;
    logic               qneg;
  } pipe_t;

  logic [3:0] frac_bits;
  logic [3:0] p_use;

  pipe_t                 st   [NUM_STAGES];
  pipe_t                 nxt  [NUM_STAGES];
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES:0]   rdy;

  // Hold the fraction-bit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= FB_RESET;
    end else if (cfg.valid) begin
      frac_bits <= cfg.data;
    end
  end

  // Clamp the format to its legal range
  always_comb begin
    p_use = frac_bits;
    if (frac_bits < 4'(FB_MIN)) p_use = 4'(FB_MIN);
    if (frac_bits > 4'(FB_MAX)) p_use = 4'(FB_MAX);
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    rdy[NUM_STAGES] = rsp.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end
  assign req.ready = rdy[0];

  // Stage logic
  always_comb begin
    logic signed [4:0] d;
    logic [4:0]        nd;
    word_t             cv;
    logic [15:0]       mask;
    logic [16:0]       amag;
    word_t             am;
    word_t             one16;
    word_t             s;
    logic [16:0]       rem_sh;
    logic              qbit;

    // Entry stage: operand prep and the single-step operations
    nxt[0]        = '0;
    nxt[0].op     = req.op;
    nxt[0].p      = p_use;
    nxt[0].a      = req.operand_a;
    nxt[0].b      = req.operand_b;
    nxt[0].g      = req.gate_value;
    one16         = word_t'(16'd1 << p_use);
    nxt[0].omg    = one16 - req.gate_value;
    nxt[0].neg_in = req.operand_a[DW-1];
    am            = req.operand_a[DW-1] ? -req.operand_a : req.operand_a;
    nxt[0].targ   = (req.op == OP_SIGMOID) ? (am >>> 1) : req.operand_a;

    d  = $signed({1'b0, req.old_frac_bits}) - $signed({1'b0, req.new_frac_bits});
    nd = 5'(-d);
    cv = d[4] ? (req.operand_a << nd[3:0]) : (req.operand_a >>> d[3:0]);
    mask = req.new_width[4] ? 16'hFFFF : ((16'd1 << req.new_width[3:0]) - 16'd1);

    amag = req.operand_a[DW-1] ? (17'd0 - {1'b1, req.operand_a})
                               : {1'b0, req.operand_a};
    nxt[0].dvd  = 32'(amag) << p_use;
    nxt[0].dvs  = req.operand_b[DW-1] ? 16'(-req.operand_b) : 16'(req.operand_b);
    nxt[0].qneg = req.operand_a[DW-1] ^ req.operand_b[DW-1];

    case (req.op)
      OP_ADD:     nxt[0].res = req.operand_a + req.operand_b;
      OP_SUB:     nxt[0].res = req.operand_a - req.operand_b;
      OP_NEG:     nxt[0].res = -req.operand_a;
      OP_ABS:     nxt[0].res = am;
      OP_CONVERT: nxt[0].res = cv & mask;
      OP_INT2FIX: nxt[0].res = req.operand_a << p_use;
      OP_DIV:     nxt[0].dz  = (req.operand_b == '0);
      default:    nxt[0].res = '0;
    endcase

    for (int i = 1; i < NUM_STAGES; i++) begin
      nxt[i] = st[i-1];

      // Divider: four restoring steps per stage
      if (i <= DIV_STAGES) begin
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
          rem_sh = {nxt[i].rem[15:0], nxt[i].dvd[31]};
          qbit   = (rem_sh >= {1'b0, nxt[i].dvs});
          if (qbit) rem_sh = rem_sh - {1'b0, nxt[i].dvs};
          nxt[i].rem = rem_sh;
          nxt[i].dvd = {nxt[i].dvd[30:0], 1'b0};
          nxt[i].quo = {nxt[i].quo[14:0], qbit};
        end
      end

      // Products and tanh core
      if (i == 1) begin
        nxt[i].prod_ab = st[i-1].a * st[i-1].b;
        nxt[i].prod_ag = st[i-1].a * st[i-1].g;
        nxt[i].prod_bo = st[i-1].b * st[i-1].omg;
        nxt[i].t       = tanh_pwl(st[i-1].targ, st[i-1].p);
      end

      // Product scaling, blend sum, tanh and sigmoid results
      if (i == 2) begin
        one16 = word_t'(16'd1 << st[i-1].p);
        s     = (st[i-1].t + one16) >>> 1;
        case (st[i-1].op)
          OP_MUL:     nxt[i].res = word_t'(st[i-1].prod_ab >>> st[i-1].p);
          OP_BLEND:   nxt[i].res = word_t'(st[i-1].prod_ag >>> st[i-1].p)
                                 + word_t'(st[i-1].prod_bo >>> st[i-1].p);
          OP_TANH:    nxt[i].res = st[i-1].t;
          OP_SIGMOID: nxt[i].res = st[i-1].neg_in ? (one16 - s) : s;
          default:    nxt[i].res = st[i-1].res;
        endcase
      end

      // Sign the quotient
      if (i == NUM_STAGES - 1) begin
        if (nxt[i].op == OP_DIV && !nxt[i].dz) begin
          nxt[i].res = nxt[i].qneg ? word_t'(-nxt[i].quo) : word_t'(nxt[i].quo);
        end
      end
    end
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= req.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (rdy[i]) st[i] <= nxt[i];
    end
  end

  assign rsp.valid          = v[NUM_STAGES-1];
  assign rsp.result         = st[NUM_STAGES-1].res;
  assign rsp.divide_by_zero = st[NUM_STAGES-1].dz;

endmodule

// ===== sv/fpa_checker.sv =====
// Checker on the response port of the fixed-point ALU, with its bind
`timescale 1ns / 1ps
`include "fixed_point_alu_with_activations_assert.svh"

module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result,
  input logic        divide_by_zero
);
  // Hold a stalled item
  `FPA_ASSERT_NEXT(a_valid_hold, clk, rst, out_valid && !out_ready, out_valid)
  `FPA_ASSERT_NEXT(a_data_hold, clk, rst, out_valid && !out_ready, $stable(result))
  // Zero divisor forces a zero result
  `FPA_ASSERT_NOW(a_dz_zero, clk, rst, out_valid && divide_by_zero, result == 16'd0)
  // Drop everything in flight on reset
  `FPA_ASSERT_ALWAYS(a_rst_empty, clk, rst, !out_valid)
endmodule

bind fixed_point_alu_with_activations fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .result        (rsp.result),
  .divide_by_zero(rsp.divide_by_zero)
);

// ===== tb/fpa_alu_checker.sv =====
// Checker: predicts each result item of the fixed-point ALU and compares it
`timescale 1ns / 1ps

module fpa_alu_checker
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fpa_cfg_if        cfg,
  fpa_req_if        req,
  fpa_rsp_if        rsp,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    word_t result;
    logic  divide_by_zero;
  } alu_out_t;

  alu_out_t   expected_q[$];
  logic [3:0] frac_reg;

  function automatic longint wrap16(longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  function automatic longint pw2(int s);
    return longint'(1) <<< s;
  endfunction

  function automatic longint q_mul(longint x, longint y, int p);
    return wrap16((x * y) >>> p);
  endfunction

  // Piecewise-linear tanh, odd-symmetric, clamped at one
  function automatic longint q_tanh(longint x, int p);
    logic   neg;
    longint fourth, half, one, two, r;
    neg = 1'b0;
    fourth = pw2(p - 2);
    half = pw2(p - 1);
    one = pw2(p);
    two = pw2(p + 1);
    r = one;
    if (x < 0) begin
      x = wrap16(-x);
      neg = 1'b1;
    end
    if (x <= fourth) begin
      r = x;
    end else if (x <= 3 * fourth) begin
      r = 3 * (x >>> 2) + 5 * pw2(p - 6);
    end else if (x <= one + fourth) begin
      r = (x >>> 1) + fourth;
    end else if (x <= two + fourth) begin
      r = (x >>> 3) + (half + fourth - pw2(p - 5));
      if (r > one) r = one;
    end
    r = wrap16(r);
    return neg ? wrap16(-r) : r;
  endfunction

  function automatic longint q_sigmoid(longint x, int p);
    logic   neg;
    longint r;
    neg = 1'b0;
    if (x < 0) begin
      x = wrap16(-x);
      neg = 1'b1;
    end
    r = wrap16(q_tanh(x >>> 1, p) + pw2(p)) >>> 1;
    if (neg) r = wrap16(pw2(p) - r);
    return r;
  endfunction

  // Expected result item for one operation under the given fraction bits
  function automatic alu_out_t alu_model(logic [3:0] fb, logic [3:0] op, word_t sa,
                                         word_t sb, word_t sg, logic [3:0] oldf,
                                         logic [3:0] newf, logic [4:0] nw);
    int       p, d;
    longint   a, b, g, r, v, mask;
    alu_out_t o;
    p = (fb < FB_MIN) ? FB_MIN : (fb > FB_MAX) ? FB_MAX : int'(fb);
    a = longint'(sa);
    b = longint'(sb);
    g = longint'(sg);
    r = 0;
    o.divide_by_zero = 1'b0;
    case (op)
      OP_ADD:     r = wrap16(a + b);
      OP_SUB:     r = wrap16(a - b);
      OP_MUL:     r = q_mul(a, b, p);
      OP_DIV: begin
        if (b == 0) o.divide_by_zero = 1'b1;
        else r = wrap16((a * pw2(p)) / b);
      end
      OP_NEG:     r = wrap16(-a);
      OP_ABS:     r = wrap16(a < 0 ? -a : a);
      OP_CONVERT: begin
        d = int'(oldf) - int'(newf);
        v = (d >= 0) ? (a >>> d) : wrap16(a * pw2(-d));
        mask = (nw >= 16) ? 64'hFFFF : (pw2(int'(nw)) - 1);
        r = wrap16(v & mask);
      end
      OP_BLEND:   r = wrap16(q_mul(a, g, p) + q_mul(b, wrap16(pw2(p) - g), p));
      OP_TANH:    r = q_tanh(a, p);
      OP_SIGMOID: r = q_sigmoid(a, p);
      OP_INT2FIX: r = wrap16(a * pw2(p));
      default:    r = 0;
    endcase
    o.result = r[15:0];
    return o;
  endfunction

  assign pending = expected_q.size();

  // Track the register, queue expectations, compare result items
  always @(posedge clk) begin
    alu_out_t e;
    if (rst) begin
      frac_reg <= FB_RESET;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg.valid && cfg.ready) frac_reg <= cfg.data;
      if (req.valid && req.ready)
        expected_q.push_back(alu_model(frac_reg, req.op, req.operand_a, req.operand_b,
                                       req.gate_value, req.old_frac_bits,
                                       req.new_frac_bits, req.new_width));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %h", rsp.result);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.result !== rsp.result || e.divide_by_zero !== rsp.divide_by_zero) begin
            if (errors < 10)
              $display("mismatch: expected %h/%b got %h/%b", e.result, e.divide_by_zero,
                       rsp.result, rsp.divide_by_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_fixed_point_alu_with_activations.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict
`timescale 1ns / 1ps

module tb_fixed_point_alu_with_activations;
  import fpa_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd11;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int DRAIN_CYCLES = 16;
  localparam int HANG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  logic stall_kick = 1'b0;
  int   stall_left = 0;
  int   errors, pending, idle_cycles;

  fpa_cfg_if cfg();
  fpa_req_if req();
  fpa_rsp_if rsp();

  fixed_point_alu_with_activations dut (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  fpa_alu_checker chk (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp),
                       .errors(errors), .pending(pending));

  always #4 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_kick) begin
      rsp.ready <= 1'b0;
      stall_left <= 150;
    end else begin
      rsp.ready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  // Watchdog: count cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("tb_fixed_point_alu_with_activations: errors");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_op(logic [3:0] op, word_t a, word_t b, word_t g,
                         logic [3:0] oldf, logic [3:0] newf, logic [4:0] nw);
    logic took;
    while (!quiet && $urandom_range(99) < 24) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    req.gate_value <= g;
    req.old_frac_bits <= oldf;
    req.new_frac_bits <= newf;
    req.new_width <= nw;
    do begin
      @(negedge clk);
      took = req.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drain the block, then write the fraction-bit register
  task automatic write_frac(logic [3:0] v);
    logic took;
    req.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do begin
      @(negedge clk);
      took = cfg.ready;
      @(posedge clk);
    end while (!took);
    cfg.valid <= 1'b0;
  endtask

  // Random item: values near the activation knees or over the full range, about half each
  task automatic send_random(int fb);
    logic [3:0] op;
    word_t      a, b, g;
    int         one;
    one = 1 << ((fb < FB_MIN) ? FB_MIN : (fb > FB_MAX) ? FB_MAX : fb);
    op = ($urandom_range(99) < 5) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                  : 4'($urandom_range(OP_ADD, OP_INT2FIX));
    a = $urandom_range(1) ? word_t'($urandom) : word_t'($urandom_range(0, 6 * one) - 3 * one);
    b = ($urandom_range(9) == 0) ? word_t'(0) : word_t'($urandom);
    if ($urandom_range(1)) b = word_t'($urandom_range(0, 4 * one) - 2 * one);
    g = $urandom_range(1) ? word_t'($urandom) : word_t'($urandom_range(0, one));
    send_op(op, a, b, g, 4'($urandom), 4'($urandom), 5'($urandom));
  endtask

  initial begin
    logic [3:0] fb;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    req.valid <= 1'b0;
    req.op <= OP_ADD;
    req.operand_a <= '0;
    req.operand_b <= '0;
    req.gate_value <= '0;
    req.old_frac_bits <= '0;
    req.new_frac_bits <= '0;
    req.new_width <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every operation, special cases at the reset format
    send_op(OP_ADD, 16'sh7FFF, 16'sh0001, 0, 0, 0, 0);
    send_op(OP_SUB, -16'sh8000, 16'sh0001, 0, 0, 0, 0);
    send_op(OP_MUL, -16'sh8000, -16'sh8000, 0, 0, 0, 0);
    send_op(OP_MUL, 16'sh7FFF, -16'sh0003, 0, 0, 0, 0);
    send_op(OP_DIV, 16'sh1234, 16'sh0000, 0, 0, 0, 0);
    send_op(OP_DIV, -16'sh8000, -16'sh0001, 0, 0, 0, 0);
    send_op(OP_DIV, -16'sh0007, 16'sh0003, 0, 0, 0, 0);
    send_op(OP_NEG, -16'sh8000, 0, 0, 0, 0, 0);
    send_op(OP_ABS, -16'sh8000, 0, 0, 0, 0, 0);
    send_op(OP_ABS, -16'sh0005, 0, 0, 0, 0, 0);
    send_op(OP_CONVERT, -16'sh1235, 0, 0, 4'd15, 4'd0, 5'd16);
    send_op(OP_CONVERT, 16'sh0123, 0, 0, 4'd0, 4'd15, 5'd31);
    send_op(OP_CONVERT, -16'sh0001, 0, 0, 4'd4, 4'd2, 5'd0);
    send_op(OP_CONVERT, -16'sh0101, 0, 0, 4'd2, 4'd4, 5'd7);
    send_op(OP_BLEND, 16'sh7FFF, -16'sh8000, -16'sh8000, 0, 0, 0);
    send_op(OP_BLEND, 16'sh0400, 16'sh0200, 16'sh0200, 0, 0, 0);
    send_op(OP_TANH, -16'sh8000, 0, 0, 0, 0, 0);
    send_op(OP_TANH, 16'sh0100, 0, 0, 0, 0, 0);
    send_op(OP_TANH, 16'sh0300, 0, 0, 0, 0, 0);
    send_op(OP_TANH, -16'sh0500, 0, 0, 0, 0, 0);
    send_op(OP_TANH, 16'sh0900, 0, 0, 0, 0, 0);
    send_op(OP_SIGMOID, -16'sh8000, 0, 0, 0, 0, 0);
    send_op(OP_SIGMOID, -16'sh0600, 0, 0, 0, 0, 0);
    send_op(OP_INT2FIX, 16'sh7FFF, 0, 0, 0, 0, 0);
    send_op(OP_SPARE_HI, 16'sh7FFF, 16'sh0000, 0, 0, 0, 0);

    // Random phases over several formats, extremes and out-of-range among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: fb = 4'd0;
        1: fb = 4'd6;
        2: fb = 4'd13;
        3: fb = 4'd15;
        default: fb = 4'($urandom);
      endcase
      write_frac(fb);
      for (int i = 0; i < 135; i++) begin
        quiet <= (ph == 2) && (i >= 20) && (i < 90);
        if (ph == 4 && i == 40) stall_kick <= 1'b1;
        else if (ph == 4 && i == 41) stall_kick <= 1'b0;
        if (ph == 5 && i == 60) begin
          req.valid <= 1'b0;
          @(negedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        send_random(fb);
      end
    end
    req.valid <= 1'b0;
    stall_kick <= 1'b0;
    quiet <= 1'b0;

    @(negedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fixed_point_alu_with_activations: clean");
    end else begin
      $display("tb_fixed_point_alu_with_activations: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_req_if.sv
sv/fpa_rsp_if.sv
sv/fpa_cfg_if.sv
sv/fixed_point_alu_with_activations.sv
sv/fpa_checker.sv
tb/fpa_alu_checker.sv
tb/tb_fixed_point_alu_with_activations.sv
